### design/kse_pkg.sv
// ----------------------------------------------------------------------------
// kse_pkg - shared types and constants for the key sort engine
// Payload structs, chain commands and control state shared by the cells,
// the controller, the top level and the checker.
// ----------------------------------------------------------------------------
package kse_pkg;

    // Store depth and key width
    localparam int MAX_KEYS     = 64;
    localparam int KEY_BITS     = 32;
    localparam int KEY_MSB      = KEY_BITS - 1;
    localparam int CNT_W        = $clog2(MAX_KEYS + 1);
    localparam int IN_KEY_W     = 32;
    localparam int SORTED_KEY_W = 32;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // Input transaction
    typedef struct packed {
        logic [IN_KEY_W-1:0] key;
        logic                end_of_set;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [SORTED_KEY_W-1:0] sorted_key;
        logic                    final_key;
        logic                    overflowed;
    } out_item_t;

    // Operation applied to every cell of the chain in a cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP,
        OP_ROTATE
    } chain_op_t;

    typedef struct packed {
        chain_op_t op;
        key_t      new_key;
        key_t      head_key;
    } chain_cmd_t;

    // Controller state
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } ctrl_state_t;

endpackage

### design/kse_cell.sv
// ----------------------------------------------------------------------------
// kse_cell - one slot of the insertion chain
// Holds one key and its valid bit. On insert it keeps its key, takes the
// new key or its left neighbor's key; on pop it takes its right neighbor's
// key; on rotate an occupied slot takes it too, or the head key if last.
// ----------------------------------------------------------------------------
module kse_cell
    import kse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  chain_cmd_t cmd,
    input  logic       left_valid,
    input  logic       left_le,
    input  key_t       left_key,
    input  logic       right_valid,
    input  key_t       right_key,
    output logic       cell_valid,
    output logic       cell_le,
    output key_t       cell_key
);

    logic valid_reg, valid_next;
    key_t key_reg, key_next;

    // Held key is no larger than the key being inserted (unsigned order)
    assign cell_le    = valid_reg && (key_reg <= cmd.new_key);
    assign cell_valid = valid_reg;
    assign cell_key   = key_reg;

    // Next slot contents
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        case (cmd.op)
            OP_INSERT: begin
                if (cell_le) begin
                    valid_next = valid_reg;
                end else if (left_le) begin
                    valid_next = 1'b1;
                    key_next   = cmd.new_key;
                end else begin
                    valid_next = left_valid;
                    key_next   = left_key;
                end
            end
            OP_POP: begin
                valid_next = right_valid;
                key_next   = right_key;
            end
            OP_ROTATE: begin
                // last occupied slot takes the head key
                if (valid_reg) begin
                    key_next = right_valid ? right_key : cmd.head_key;
                end
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

### design/kse_ctrl.sv
// ----------------------------------------------------------------------------
// kse_ctrl - load and drain sequencer
// Counts held keys, tracks overflow and keys with the sign bit set, and
// issues one chain command a cycle. In signed mode the unsigned-sorted
// chain is rotated so the negative keys come out first.
// ----------------------------------------------------------------------------
module kse_ctrl
    import kse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  key_t       head_key,
    input  logic       second_valid,
    output chain_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    cnt_t        held_reg, held_next;
    cnt_t        neg_reg, neg_next;
    logic        ovf_reg, ovf_next;
    logic        signed_keys_reg;
    logic        rotate;
    key_t        in_key;

    assign in_key = KEY_BITS'(s_data.key);

    // Head is a non-negative key while negative keys still wait behind it
    assign rotate = signed_keys_reg && !head_key[KEY_MSB] && (neg_reg != '0);

    // Result payload straight from the head cell
    assign m_data.sorted_key = SORTED_KEY_W'(head_key);
    assign m_data.final_key  = !second_valid;
    assign m_data.overflowed = ovf_reg;

    // Next state, counters and chain command
    always_comb begin
        state_next   = state_reg;
        held_next    = held_reg;
        neg_next     = neg_reg;
        ovf_next     = ovf_reg;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        cmd.op       = OP_HOLD;
        cmd.new_key  = in_key;
        cmd.head_key = head_key;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (held_reg < cnt_t'(MAX_KEYS)) begin
                        cmd.op    = OP_INSERT;
                        held_next = held_reg + cnt_t'(1);
                        neg_next  = neg_reg + cnt_t'(in_key[KEY_MSB]);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.end_of_set) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (rotate) begin
                    cmd.op = OP_ROTATE;
                end else begin
                    m_valid = 1'b1;
                    if (m_ready) begin
                        cmd.op   = OP_POP;
                        neg_next = neg_reg - cnt_t'(head_key[KEY_MSB]);
                        if (!second_valid) begin
                            state_next = ST_LOAD;
                            held_next  = '0;
                            neg_next   = '0;
                            ovf_next   = 1'b0;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            held_reg        <= '0;
            neg_reg         <= '0;
            ovf_reg         <= 1'b0;
            signed_keys_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            held_reg  <= held_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            if (cfg_wr_en) begin
                signed_keys_reg <= cfg_wr_data;
            end
        end
    end

endmodule

### design/key_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// key_sort_engine_unit - ascending key sorter, insertion chain
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    in_item_t  (key, end_of_set)
//   m_        out        m_valid / m_ready    out_item_t (sorted_key, final_key,
//                                                          overflowed)
//   cfg_      in         cfg_wr_en            cfg_wr_data (signed_keys)
//
// While loading, every cell compares against the new key and the chain
// opens a slot in the same cycle. After the closing key the set drains
// from the head cell, one key per cycle while m_ready is high; in signed
// mode rotate steps come first, one per non-negative key moved behind
// the negative ones. s_ready is low while draining. A stalled result
// holds in the head cell. Reset is synchronous and empties the chain.
// ----------------------------------------------------------------------------
module key_sort_engine_unit
    import kse_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    chain_cmd_t cmd;
    logic       cell_valid [MAX_KEYS];
    logic       cell_le    [MAX_KEYS];
    key_t       cell_key   [MAX_KEYS];

    // Sequencer
    kse_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .head_key     (cell_key[0]),
        .second_valid (cell_valid[1]),
        .cmd          (cmd)
    );

    // Row of cells, head at index 0
    for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
        logic left_valid, left_le, right_valid;
        key_t left_key, right_key;

        if (i == 0) begin : g_head
            assign left_valid = 1'b0;
            assign left_le    = 1'b1;
            assign left_key   = '0;
        end else begin : g_body
            assign left_valid = cell_valid[i-1];
            assign left_le    = cell_le[i-1];
            assign left_key   = cell_key[i-1];
        end

        if (i == MAX_KEYS - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_key   = '0;
        end else begin : g_inner
            assign right_valid = cell_valid[i+1];
            assign right_key   = cell_key[i+1];
        end

        kse_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .left_valid  (left_valid),
            .left_le     (left_le),
            .left_key    (left_key),
            .right_valid (right_valid),
            .right_key   (right_key),
            .cell_valid  (cell_valid[i]),
            .cell_le     (cell_le[i]),
            .cell_key    (cell_key[i])
        );
    end

endmodule

### design/kse_checker.sv
// ----------------------------------------------------------------------------
// kse_port_checks - port-level checks for the key sort engine
// Watches load/drain alternation and result flow on the top level ports.
// ----------------------------------------------------------------------------
module kse_port_checks
    import kse_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      cfg_wr_en,
    input logic      cfg_wr_data,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Never loading and draining at once
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is offered");

    // Closing transaction starts the drain
    a_close_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.end_of_set) |=> !s_ready)
        else $error("input still ready after the closing key");

    // Final result reopens the input
    a_final_reloads: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.final_key) |=> (s_ready && !m_valid))
        else $error("input not reopened after the final key");

    // Once output has started, results follow without gaps
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.final_key) |=> m_valid)
        else $error("gap inside a sorted set");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind key_sort_engine_unit kse_port_checks u_kse_port_checks (.*);
